### rtl/wlmd_pkg.sv
// shared constants and types of the window local maximum detector
package wlmd_pkg;

    localparam int MAX_ROW_PIXELS = 1024;
    localparam int MAX_RADIUS     = 4;
    localparam int ROW_SLOTS      = 2 * MAX_RADIUS;
    localparam int COL_TAPS       = 2 * MAX_RADIUS + 1;
    localparam int CEN_TAPS       = MAX_RADIUS + 1;

    localparam int PIX_W    = 16;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 12;
    localparam int WIDTH_W  = 11;
    localparam int RADIUS_W = 3;
    localparam int CFG_W    = 16;

    localparam int ADDR_W   = $clog2(MAX_ROW_PIXELS);
    localparam int SLOT_W   = $clog2(ROW_SLOTS);
    localparam int SPAN_W   = RADIUS_W + 1;

    localparam int OUT_DEPTH = 4;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1) + 1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [ROW_W-1:0]    HEIGHT_RESET = ROW_W'(480);
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);
    localparam logic [PIX_W-1:0]    LEVEL_RESET  = '0;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_WINDOW_RADIUS  = 2'd2,
        CFG_MIN_PEAK_LEVEL = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [COL_W-1:0] centre_x;
        logic [ROW_W-1:0] centre_y;
        logic             is_peak;
        logic             frame_done;
    } result_t;

endpackage

### rtl/window_local_max_detector_top.sv
// local maximum detector over a square window with a column-wide line store
// a result passes stage 1, stage 2 and the result queue before it reaches the output
// throughput: one pixel per clock while in_ready is high; line store read and write share the accept edge
// a 4-entry result queue lets input continue while results wait downstream
// reset: registers go to 640 x 480, radius 1, level 0; counters and taps clear
// the line store is not cleared at reset and holds unknown data until written
module window_local_max_detector_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  wlmd_pkg::cfg_reg_t                     cfg_index,
    input  logic [wlmd_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [wlmd_pkg::PIX_W-1:0]      pixel_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [wlmd_pkg::COL_W-1:0]             centre_x,
    output logic [wlmd_pkg::ROW_W-1:0]             centre_y,
    output logic                                   is_peak,
    output logic                                   frame_done
);
    import wlmd_pkg::*;

    // configuration
    logic [WIDTH_W-1:0]      width_reg;
    logic [ROW_W-1:0]        height_reg;
    logic [RADIUS_W-1:0]     radius_reg;
    logic signed [PIX_W-1:0] level_reg;

    logic [WIDTH_W-1:0]  w_eff;
    logic [ROW_W-1:0]    h_eff;
    logic [RADIUS_W-1:0] r_eff;

    // position counters
    logic [COL_W-1:0] x_reg, x_next;
    logic [ROW_W-1:0] y_reg, y_next;

    // line store
    logic [ROW_SLOTS-1:0][PIX_W-1:0] row_mem [MAX_ROW_PIXELS];
    logic [ROW_SLOTS-1:0][PIX_W-1:0] rd_word_reg;

    // stage 1
    logic                    s1_valid_reg;
    logic signed [PIX_W-1:0] s1_pix_reg;
    logic [SLOT_W-1:0]       s1_slot_reg;
    logic [RADIUS_W-1:0]     s1_r_reg;
    logic [COL_W-1:0]        s1_cx_reg;
    logic [ROW_W-1:0]        s1_cy_reg;
    logic                    s1_produce_reg;
    logic                    s1_last_reg;
    logic signed [PIX_W-1:0] s1_colmax;
    logic signed [PIX_W-1:0] s1_cen_in;

    // stage 2
    logic                    s2_valid_reg;
    logic [RADIUS_W-1:0]     s2_r_reg;
    logic [COL_W-1:0]        s2_cx_reg;
    logic [ROW_W-1:0]        s2_cy_reg;
    logic                    s2_produce_reg;
    logic                    s2_last_reg;
    logic signed [PIX_W-1:0] colmax_sh_reg [COL_TAPS];
    logic signed [PIX_W-1:0] cen_sh_reg [CEN_TAPS];
    logic signed [PIX_W-1:0] s2_cen;
    logic                    s2_peak;
    result_t                 s2_result;

    // result queue
    result_t             oq_mem [OUT_DEPTH];
    logic [OPTR_W-1:0]   oq_wr_reg, oq_wr_next;
    logic [OPTR_W-1:0]   oq_rd_reg, oq_rd_next;
    logic [OCNT_W-1:0]   oq_cnt_reg, oq_cnt_next;
    logic                oq_push;
    logic                oq_pop;
    result_t             oq_head;

    logic                accept;
    logic                acc_produce;
    logic                acc_last;
    logic [SPAN_W-1:0]   acc_span;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            radius_reg <= RADIUS_RESET;
            level_reg  <= LEVEL_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:    width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:   height_reg <= cfg_data[ROW_W-1:0];
                CFG_WINDOW_RADIUS:  radius_reg <= cfg_data[RADIUS_W-1:0];
                CFG_MIN_PEAK_LEVEL: level_reg  <= cfg_data[PIX_W-1:0];
            endcase
        end
    end

    // clamp registers into the supported range
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WIDTH_W'(1);
        else if (width_reg > WIDTH_W'(MAX_ROW_PIXELS))
            w_eff = WIDTH_W'(MAX_ROW_PIXELS);
        else
            w_eff = width_reg;
        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
        r_eff = (radius_reg > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_reg;
    end

    always_comb
    begin
        acc_span    = {r_eff, 1'b0};
        acc_produce = ({1'b0, x_reg} >= WIDTH_W'(acc_span)) &&
                      ({1'b0, x_reg} < w_eff) &&
                      (y_reg >= ROW_W'(acc_span)) && (y_reg < h_eff);
        acc_last    = ({1'b0, x_reg} == (w_eff - WIDTH_W'(1))) &&
                      (y_reg == (h_eff - ROW_W'(1)));
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (accept)
        begin
            if (({1'b0, x_reg} + WIDTH_W'(1)) >= w_eff)
            begin
                x_next = '0;
                if (({1'b0, y_reg} + (ROW_W+1)'(1)) >= {1'b0, h_eff})
                    y_next = '0;
                else
                    y_next = y_reg + ROW_W'(1);
            end
            else
            begin
                x_next = x_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    // read the column before this pixel lands in its own row slot
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_mem[x_reg[ADDR_W-1:0]][y_reg[SLOT_W-1:0]] <= pixel_value;
            rd_word_reg <= row_mem[x_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg     <= pixel_value;
            s1_slot_reg    <= y_reg[SLOT_W-1:0];
            s1_r_reg       <= r_eff;
            s1_cx_reg      <= x_reg - COL_W'(r_eff);
            s1_cy_reg      <= y_reg - ROW_W'(r_eff);
            s1_produce_reg <= acc_produce;
            s1_last_reg    <= acc_last;
        end
    end

    // column maximum over the window rows
    always_comb
    begin
        logic signed [PIX_W-1:0] v;
        s1_colmax = s1_pix_reg;
        s1_cen_in = s1_pix_reg;
        for (int k = 1; k <= ROW_SLOTS; k++)
        begin
            v = $signed(rd_word_reg[SLOT_W'(s1_slot_reg - SLOT_W'(k))]);
            if ((SPAN_W'(k) <= {s1_r_reg, 1'b0}) && (v > s1_colmax))
                s1_colmax = v;
        end
        if (s1_r_reg != '0)
            s1_cen_in = $signed(rd_word_reg[SLOT_W'(s1_slot_reg - SLOT_W'(s1_r_reg))]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            for (int i = 0; i < COL_TAPS; i++)
                colmax_sh_reg[i] <= '0;
            for (int i = 0; i < CEN_TAPS; i++)
                cen_sh_reg[i] <= '0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                colmax_sh_reg[0] <= s1_colmax;
                for (int i = 1; i < COL_TAPS; i++)
                    colmax_sh_reg[i] <= colmax_sh_reg[i-1];
                cen_sh_reg[0] <= s1_cen_in;
                for (int i = 1; i < CEN_TAPS; i++)
                    cen_sh_reg[i] <= cen_sh_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_r_reg       <= s1_r_reg;
            s2_cx_reg      <= s1_cx_reg;
            s2_cy_reg      <= s1_cy_reg;
            s2_produce_reg <= s1_produce_reg;
            s2_last_reg    <= s1_last_reg;
        end
    end

    // peak when the centre reaches the minimum level and no tap of the window is above it
    always_comb
    begin
        s2_cen  = cen_sh_reg[s2_r_reg];
        s2_peak = (s2_cen >= level_reg);
        for (int i = 0; i < COL_TAPS; i++)
        begin
            if ((SPAN_W'(i) <= {s2_r_reg, 1'b0}) && (colmax_sh_reg[i] > s2_cen))
                s2_peak = 1'b0;
        end
        s2_result.centre_x   = s2_cx_reg;
        s2_result.centre_y   = s2_cy_reg;
        s2_result.is_peak    = s2_peak;
        s2_result.frame_done = s2_last_reg;
    end

    assign oq_push = s2_valid_reg && s2_produce_reg;
    assign oq_pop  = out_valid && out_ready;

    always_comb
    begin
        oq_wr_next  = oq_push ? oq_wr_reg + OPTR_W'(1) : oq_wr_reg;
        oq_rd_next  = oq_pop ? oq_rd_reg + OPTR_W'(1) : oq_rd_reg;
        oq_cnt_next = oq_cnt_reg + OCNT_W'(oq_push) - OCNT_W'(oq_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            oq_wr_reg  <= oq_wr_next;
            oq_rd_reg  <= oq_rd_next;
            oq_cnt_reg <= oq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
            oq_mem[oq_wr_reg] <= s2_result;
    end

    // room for every request still in flight
    assign in_ready = (oq_cnt_reg + OCNT_W'(s1_valid_reg) + OCNT_W'(s2_valid_reg))
                      < OCNT_W'(OUT_DEPTH);

    assign oq_head    = oq_mem[oq_rd_reg];
    assign out_valid  = (oq_cnt_reg != '0);
    assign centre_x   = oq_head.centre_x;
    assign centre_y   = oq_head.centre_y;
    assign is_peak    = oq_head.is_peak;
    assign frame_done = oq_head.frame_done;

    a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg <= OCNT_W'(OUT_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (oq_push && !oq_pop) |-> (oq_cnt_reg < OCNT_W'(OUT_DEPTH)))
        else $error("result pushed into a full queue");

    a_accept_reaches_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted request lost before stage 1");

    a_s1_reaches_s2: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> s2_valid_reg)
        else $error("stage 1 request lost before stage 2");

    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ({1'b0, x_reg} + WIDTH_W'(1) < w_eff)) |=> (x_reg == $past(x_reg) + COL_W'(1)))
        else $error("column counter did not advance");

endmodule

### sim/testbench.sv
// self-checking testbench for the window local maximum detector
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wlmd_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    cfg_reg_t           cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [PIX_W-1:0] pixel_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COL_W-1:0]   centre_x;
    logic [ROW_W-1:0]   centre_y;
    logic               is_peak;
    logic               frame_done;

    window_local_max_detector_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_value (pixel_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .centre_x    (centre_x),
        .centre_y    (centre_y),
        .is_peak     (is_peak),
        .frame_done  (frame_done)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // detector model state
    logic [WIDTH_W-1:0]      cur_width  = WIDTH_RESET;
    logic [ROW_W-1:0]        cur_height = HEIGHT_RESET;
    logic [RADIUS_W-1:0]     cur_radius = RADIUS_RESET;
    logic signed [PIX_W-1:0] cur_level  = LEVEL_RESET;
    logic signed [PIX_W-1:0] line_rows [ROW_SLOTS][MAX_ROW_PIXELS] = '{default: '0};
    logic signed [PIX_W-1:0] colmax_taps [COL_TAPS] = '{default: '0};
    logic signed [PIX_W-1:0] centre_taps [CEN_TAPS] = '{default: '0};
    int                      col_count = 0;
    int                      row_count = 0;

    logic [PIX_W-1:0] pending_pixels [$];
    result_t          expected_centres [$];
    int               fail_count = 0;
    int               cycle_count = 0;
    int               hold_left = 0;
    logic             hold_armed = 1'b0;
    logic             hold_used = 1'b0;

    wire no_idle_stretch = (cycle_count >= 3000) && (cycle_count < 6000);

    function automatic int eff_width();
        if (cur_width == 0)
            return 1;
        if (cur_width > MAX_ROW_PIXELS)
            return MAX_ROW_PIXELS;
        return int'(cur_width);
    endfunction

    function automatic int eff_height();
        return (cur_height == 0) ? 1 : int'(cur_height);
    endfunction

    function automatic int eff_radius();
        return (cur_radius > MAX_RADIUS) ? MAX_RADIUS : int'(cur_radius);
    endfunction

    task automatic update_peak_detector(input logic signed [PIX_W-1:0] pix);
        int w;
        int h;
        int r;
        int x;
        int y;
        int k;
        int slot;
        logic signed [PIX_W-1:0] colmax;
        logic signed [PIX_W-1:0] cen_in;
        logic signed [PIX_W-1:0] cen;
        logic signed [PIX_W-1:0] winmax;
        logic signed [PIX_W-1:0] v;
        result_t res;
        w = eff_width();
        h = eff_height();
        r = eff_radius();
        x = col_count;
        y = row_count;
        colmax = pix;
        cen_in = pix;
        // earlier window rows at this column, read before the new pixel lands
        for (k = 1; k <= 2 * r; k++)
        begin
            slot = (y % ROW_SLOTS + ROW_SLOTS - (k % ROW_SLOTS)) % ROW_SLOTS;
            v = line_rows[slot][x];
            if (v > colmax)
                colmax = v;
            if (k == r)
                cen_in = v;
        end
        line_rows[y % ROW_SLOTS][x] = pix;
        for (k = COL_TAPS - 1; k > 0; k--)
            colmax_taps[k] = colmax_taps[k-1];
        colmax_taps[0] = colmax;
        for (k = CEN_TAPS - 1; k > 0; k--)
            centre_taps[k] = centre_taps[k-1];
        centre_taps[0] = cen_in;
        if (x >= 2 * r && x < w && y >= 2 * r && y < h)
        begin
            cen = centre_taps[r];
            winmax = colmax_taps[0];
            for (k = 1; k <= 2 * r; k++)
                if (colmax_taps[k] > winmax)
                    winmax = colmax_taps[k];
            res.centre_x   = COL_W'(x - r);
            res.centre_y   = ROW_W'(y - r);
            res.is_peak    = (cen >= cur_level) && (winmax <= cen);
            res.frame_done = (x == w - 1) && (y == h - 1);
            expected_centres.push_back(res);
        end
        if (x + 1 >= w)
        begin
            col_count = 0;
            row_count = (y + 1 >= h) ? 0 : y + 1;
        end
        else
        begin
            col_count = x + 1;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // pixel request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            pixel_value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                update_peak_detector(pixel_value);
            if (!in_valid || in_ready)
            begin
                if (pending_pixels.size() != 0 &&
                    (no_idle_stretch || $urandom_range(0, 99) >= 36))
                begin
                    in_valid    <= 1'b1;
                    pixel_value <= pending_pixels.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else
        begin : monitor
            result_t want;
            if (out_valid && out_ready)
            begin
                if (expected_centres.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result x=%0d y=%0d peak=%0d done=%0d",
                                 centre_x, centre_y, is_peak, frame_done);
                end
                else
                begin
                    want = expected_centres.pop_front();
                    if (centre_x !== want.centre_x || centre_y !== want.centre_y ||
                        is_peak !== want.is_peak || frame_done !== want.frame_done)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected x=%0d y=%0d peak=%0d done=%0d, %s",
                                     want.centre_x, want.centre_y, want.is_peak,
                                     want.frame_done,
                                     $sformatf("got x=%0d y=%0d peak=%0d done=%0d",
                                               centre_x, centre_y, is_peak, frame_done));
                    end
                end
            end
            // long hold-off so the result queue fills and input backs up
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_armed && !hold_used)
            begin
                out_ready <= 1'b0;
                hold_left <= 200;
                hold_used <= 1'b1;
            end
            else
            begin
                out_ready <= no_idle_stretch || ($urandom_range(0, 99) >= 36);
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_IMAGE_WIDTH:    cur_width  = value[WIDTH_W-1:0];
            CFG_IMAGE_HEIGHT:   cur_height = value[ROW_W-1:0];
            CFG_WINDOW_RADIUS:  cur_radius = value[RADIUS_W-1:0];
            CFG_MIN_PEAK_LEVEL: cur_level  = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_W-1:0] wid, input logic [CFG_W-1:0] hgt,
                             input logic [CFG_W-1:0] rad, input logic [CFG_W-1:0] lvl);
        write_reg(CFG_IMAGE_WIDTH, wid);
        write_reg(CFG_IMAGE_HEIGHT, hgt);
        write_reg(CFG_WINDOW_RADIUS, rad);
        write_reg(CFG_MIN_PEAK_LEVEL, lvl);
    endtask

    // nothing queued, nothing in flight, pipeline flushed
    task automatic wait_idle();
        do
        begin
            while (pending_pixels.size() != 0 || in_valid || expected_centres.size() != 0)
                @(posedge clk);
            repeat (10) @(posedge clk);
        end
        while (pending_pixels.size() != 0 || in_valid || expected_centres.size() != 0);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input int style,
                                                    input logic [PIX_W-1:0] base);
        case (style)
            0: return PIX_W'($urandom);
            1: return base + PIX_W'($urandom_range(0, 3));
            default: return ($urandom_range(0, 19) == 0) ?
                            base + PIX_W'($urandom_range(1, 9)) : base;
        endcase
    endfunction

    task automatic send_frames(input int frames, input int style,
                               input logic [PIX_W-1:0] base);
        repeat (frames * eff_width() * eff_height())
            pending_pixels.push_back(pick_pixel(style, base));
    endtask

    initial
    begin
        logic [PIX_W-1:0] tie_frame [9];
        logic [PIX_W-1:0] corner_frame [9];
        logic [PIX_W-1:0] base;
        logic [CFG_W-1:0] wid;
        logic [CFG_W-1:0] hgt;
        logic [CFG_W-1:0] rad;
        logic [CFG_W-1:0] lvl;
        int               style;
        int               frames;
        int               random_pixels;
        tie_frame    = '{default: 16'd5};
        corner_frame = '{16'd10, 16'd3, 16'd3, 16'd3, 16'd9, 16'd3, 16'd3, 16'd3, 16'd3};
        random_pixels = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // zero width and height taken as one, radius zero: every pixel is a frame
        configure(16'd0, 16'd0, 16'd0, 16'h8000);
        pending_pixels.push_back(16'h8000);
        pending_pixels.push_back(16'h7fff);
        pending_pixels.push_back(16'h0000);
        pending_pixels.push_back(16'hffff);
        wait_idle();
        write_reg(CFG_MIN_PEAK_LEVEL, 16'h7fff);
        pending_pixels.push_back(16'h7fff);
        pending_pixels.push_back(16'h7ffe);
        pending_pixels.push_back(16'h8000);
        wait_idle();

        // 3x3 frames: tied window is a peak, greater corner is not
        configure(16'd3, 16'd3, 16'd1, 16'd0);
        foreach (tie_frame[i])
            pending_pixels.push_back(tie_frame[i]);
        foreach (corner_frame[i])
            pending_pixels.push_back(corner_frame[i]);
        wait_idle();

        // oversized radius clamps to the maximum, image too small for any centre
        configure(16'd4, 16'd4, 16'd7, 16'd0);
        send_frames(1, 0, '0);
        wait_idle();

        // oversized width clamps to the full row, receiver holds off meanwhile
        configure(16'd2047, 16'd1, 16'd0, 16'($urandom));
        hold_armed <= 1'b1;
        send_frames(1, 0, '0);
        wait_idle();

        // tallest frame, then height lowered below the row counter
        configure(16'd1, 16'd4095, 16'd0, 16'($urandom));
        repeat (20) pending_pixels.push_back(pick_pixel(0, '0));
        wait_idle();
        write_reg(CFG_IMAGE_HEIGHT, 16'd3);
        // one pixel to wrap the row counter, then a whole 1x3 frame
        repeat (4) pending_pixels.push_back(pick_pixel(0, '0));
        wait_idle();

        // width lowered below the column counter in mid-row
        configure(16'd10, 16'd2, 16'd0, 16'($urandom));
        repeat (7) pending_pixels.push_back(pick_pixel(0, '0));
        wait_idle();
        write_reg(CFG_IMAGE_WIDTH, 16'd4);
        repeat (5) pending_pixels.push_back(pick_pixel(0, '0));
        wait_idle();

        while (random_pixels < 350)
        begin
            base  = PIX_W'($urandom);
            style = $urandom_range(0, 2);
            rad = 16'($urandom_range(0, 7));
            wid = 16'($urandom_range(1, 20));
            hgt = 16'($urandom_range(1, 14));
            case ($urandom_range(0, 9))
                0: wid = 16'd0;
                1: hgt = 16'd0;
                default: ;
            endcase
            case ($urandom_range(0, 4))
                0: lvl = 16'($urandom);
                1: lvl = 16'h8000;
                2: lvl = 16'h7fff;
                3: lvl = base + 16'($urandom_range(0, 3));
                default: lvl = base - 16'd1;
            endcase
            configure(wid, hgt, rad, lvl);
            frames = $urandom_range(1, 3);
            send_frames(frames, style, base);
            random_pixels += frames * eff_width() * eff_height();
            wait_idle();
        end

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #800_000;
        $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/wlmd_pkg.sv
rtl/window_local_max_detector_top.sv
sim/testbench.sv
